// File: hdl/dtw_pkg.sv
// Shared types and constants of the DDS tuning word writer.
// Used by every module of the block; depends on nothing.

package dtw_pkg;

  localparam int FREQ_WORD_BITS  = 28;
  localparam int PHASE_WORD_BITS = 12;

  localparam int FREQ_IN_BITS  = 32;
  localparam int PHASE_IN_BITS = 10;
  localparam int CLOCK_BITS    = 32;
  localparam int SPI_BITS      = 16;

  localparam logic [CLOCK_BITS-1:0] CLOCK_HZ_RESET = 32'd75000000;

  // round(2^48 / (2*pi)) and its binary point
  localparam int                   PHASE_K_BITS    = 46;
  localparam int                   PHASE_FRAC_BITS = 48;
  localparam logic [PHASE_K_BITS-1:0] PHASE_K      = 46'd44798133900177;

  localparam logic [SPI_BITS-1:0] FREQ_PREFIX_ONE   = 16'h8000;
  localparam logic [SPI_BITS-1:0] FREQ_PREFIX_ZERO  = 16'h4000;
  localparam logic [SPI_BITS-1:0] PHASE_PREFIX_ONE  = 16'hE000;
  localparam logic [SPI_BITS-1:0] PHASE_PREFIX_ZERO = 16'hC000;

  localparam int FREQ_PAYLOAD_BITS  = 14;
  localparam int PHASE_PAYLOAD_BITS = 13;

  typedef struct packed {
    logic [FREQ_IN_BITS-1:0]  freq_hz;
    logic [PHASE_IN_BITS-1:0] phase_rad;
  } in_word_t;

  typedef struct packed {
    logic [SPI_BITS-1:0] spi_word;
    logic                last;
    logic                freq_bank_sel;
    logic                phase_bank_sel;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_FREQ_MSB,
    S_FREQ_LSB,
    S_PHASE
  } dtw_state_e;

endpackage

// File: hdl/dtw_div.sv
// Bit-serial restoring divider: round(freq * 2^FREQ_WORD_BITS / clock).
// Depends on dtw_pkg.

module dtw_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [dtw_pkg::FREQ_IN_BITS-1:0]    freq_i,
  input  logic [dtw_pkg::CLOCK_BITS-1:0]      clock_i,
  output logic                                busy_o,
  output logic [dtw_pkg::FREQ_WORD_BITS-1:0]  word_o
);
  import dtw_pkg::*;

  localparam int DIV_STEPS = FREQ_IN_BITS + FREQ_WORD_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  logic                      busy_q, busy_d;
  logic [DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [FREQ_IN_BITS-1:0]   num_q, num_d;
  logic [CLOCK_BITS-1:0]     rem_q, rem_d;
  logic [FREQ_WORD_BITS-1:0] quo_q, quo_d;
  logic [FREQ_WORD_BITS-1:0] word_q, word_d;
  logic [CLOCK_BITS:0]       trial;
  logic [CLOCK_BITS+1:0]     diff;
  logic                      fits;
  logic                      round_up;

  // one quotient bit a cycle: bring down the next dividend bit, trial subtract
  assign trial    = {rem_q, num_q[FREQ_IN_BITS-1]};
  assign diff     = {1'b0, trial} - {2'b00, clock_i};
  assign fits     = ~diff[CLOCK_BITS+1];
  assign round_up = ({rem_q, 1'b0} >= {1'b0, clock_i});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    word_d = word_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = freq_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
        busy_d = 1'b0;
        if (clock_i == '0) begin
          word_d = '1;
        end else begin
          word_d = quo_q + FREQ_WORD_BITS'(round_up);
        end
      end else begin
        cnt_d = cnt_q + DIV_CNT_W'(1);
        num_d = {num_q[FREQ_IN_BITS-2:0], 1'b0};
        rem_d = fits ? diff[CLOCK_BITS-1:0] : trial[CLOCK_BITS-1:0];
        quo_d = {quo_q[FREQ_WORD_BITS-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    word_q <= word_d;
  end

  assign busy_o = busy_q;
  assign word_o = word_q;

endmodule

// File: hdl/dtw_pmul.sv
// Bit-serial shift-and-add multiplier for the phase word, with rounding.
// Depends on dtw_pkg.

module dtw_pmul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [dtw_pkg::PHASE_IN_BITS-1:0]    phase_i,
  output logic                                 busy_o,
  output logic [dtw_pkg::PHASE_WORD_BITS-1:0]  word_o
);
  import dtw_pkg::*;

  localparam int PROD_W   = PHASE_IN_BITS + PHASE_K_BITS;
  localparam int MUL_CNT_W = $clog2(PHASE_IN_BITS + 1);
  localparam int PW_LO    = PHASE_FRAC_BITS - PHASE_WORD_BITS;

  logic                     busy_q, busy_d;
  logic [MUL_CNT_W-1:0]     cnt_q, cnt_d;
  logic [PHASE_IN_BITS-1:0] ph_q, ph_d;
  logic [PROD_W-1:0]        acc_q, acc_d;
  logic [PROD_W-1:0]        addend;

  // multiplier bits MSB first: double the sum, add K where the bit is set
  assign addend = ph_q[PHASE_IN_BITS-1] ? PROD_W'(PHASE_K) : '0;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ph_d   = phase_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = {acc_q[PROD_W-2:0], 1'b0} + addend;
      ph_d  = {ph_q[PHASE_IN_BITS-2:0], 1'b0};
      cnt_d = cnt_q + MUL_CNT_W'(1);
      if (cnt_q == MUL_CNT_W'(PHASE_IN_BITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= ph_d;
    acc_q <= acc_d;
  end

  // round half up at the bit below the word
  assign busy_o = busy_q;
  assign word_o = acc_q[PHASE_FRAC_BITS-1:PW_LO]
                + PHASE_WORD_BITS'(acc_q[PW_LO-1]);

endmodule

// File: hdl/dds_tuning_word_writer_unit.sv
// Top level of the DDS tuning word writer: request compare, control, framing.
// Depends on dtw_pkg, dtw_div and dtw_pmul.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_word_i  (in_word_t)
//   out     | output    | out_valid_o / out_stall_i  | out_word_o (out_word_t)
//   cfg     | input     | cfg_we_i                   | cfg_wdata_i (clock, Hz)
//
// An unchanged request is accepted and sends nothing. A changed one is accepted,
// then runs through the serial divider (quotient bits, then a rounding step, with
// the phase multiply alongside), leaves the wait and loads the three words. Reset
// clears the stored request, selects bank one and loads 75 MHz. A stall on the
// output holds the word register and delays the next load; the next request is
// taken while the last word waits.

module dds_tuning_word_writer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dtw_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dtw_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [dtw_pkg::CLOCK_BITS-1:0] cfg_wdata_i
);
  import dtw_pkg::*;

  dtw_state_e                 state_q, state_d;
  logic [FREQ_IN_BITS-1:0]    cur_freq_q;
  logic [PHASE_IN_BITS-1:0]   cur_phase_q;
  logic                       bank_one_q, bank_one_d;
  logic [CLOCK_BITS-1:0]      clock_hz_q;
  logic                       out_valid_q, out_valid_d;
  out_word_t                  out_q, out_d;

  logic                       accept;
  logic                       changed;
  logic                       start;
  logic                       load;
  logic                       div_busy;
  logic                       mul_busy;
  logic [FREQ_WORD_BITS-1:0]  freq_word;
  logic [PHASE_WORD_BITS-1:0] phase_word;
  logic [31:0]                freq_ext;
  logic [15:0]                phase_ext;
  logic [SPI_BITS-1:0]        freq_prefix;
  logic [SPI_BITS-1:0]        phase_prefix;

  dtw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .freq_i  (in_word_i.freq_hz),
    .clock_i (clock_hz_q),
    .busy_o  (div_busy),
    .word_o  (freq_word)
  );

  dtw_pmul u_pmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .phase_i (in_word_i.phase_rad),
    .busy_o  (mul_busy),
    .word_o  (phase_word)
  );

  // take requests only while nothing is being worked on
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign changed    = (in_word_i.freq_hz != cur_freq_q)
                   || (in_word_i.phase_rad != cur_phase_q);
  assign start      = accept && changed;

  // load a word when the register is empty or its word leaves this cycle
  assign load = !out_valid_q || !out_stall_i;

  assign freq_ext     = 32'(freq_word);
  assign phase_ext    = 16'(phase_word);
  assign freq_prefix  = bank_one_q ? FREQ_PREFIX_ONE  : FREQ_PREFIX_ZERO;
  assign phase_prefix = bank_one_q ? PHASE_PREFIX_ONE : PHASE_PREFIX_ZERO;

  always_comb begin
    state_d     = state_q;
    bank_one_d  = bank_one_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (!div_busy && !mul_busy) begin
          state_d = S_FREQ_MSB;
        end
      end
      S_FREQ_MSB: begin
        if (load) begin
          out_d.spi_word       = freq_prefix
                               | {2'b00, freq_ext[2*FREQ_PAYLOAD_BITS-1:FREQ_PAYLOAD_BITS]};
          out_d.last           = 1'b0;
          out_d.freq_bank_sel  = 1'b0;
          out_d.phase_bank_sel = 1'b0;
          out_valid_d          = 1'b1;
          state_d              = S_FREQ_LSB;
        end
      end
      S_FREQ_LSB: begin
        if (load) begin
          out_d.spi_word       = freq_prefix | {2'b00, freq_ext[FREQ_PAYLOAD_BITS-1:0]};
          out_d.last           = 1'b0;
          out_d.freq_bank_sel  = 1'b0;
          out_d.phase_bank_sel = 1'b0;
          out_valid_d          = 1'b1;
          state_d              = S_PHASE;
        end
      end
      S_PHASE: begin
        // bank pins follow the bank just written, then flip the bank
        if (load) begin
          out_d.spi_word       = phase_prefix | {3'b000, phase_ext[PHASE_PAYLOAD_BITS-1:0]};
          out_d.last           = 1'b1;
          out_d.freq_bank_sel  = bank_one_q;
          out_d.phase_bank_sel = bank_one_q;
          out_valid_d          = 1'b1;
          bank_one_d           = !bank_one_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_freq_q  <= '0;
      cur_phase_q <= '0;
      bank_one_q  <= 1'b1;
      clock_hz_q  <= CLOCK_HZ_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_one_q  <= bank_one_d;
      out_valid_q <= out_valid_d;
      if (start) begin
        cur_freq_q  <= in_word_i.freq_hz;
        cur_phase_q <= in_word_i.phase_rad;
      end
      if (cfg_we_i) begin
        clock_hz_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hdl/dtw_checker.sv
// Port-level checks on the DDS tuning word writer, and their bind.
// Depends on dtw_pkg and dds_tuning_word_writer_unit.

module dtw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input dtw_pkg::in_word_t              in_word_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input dtw_pkg::out_word_t             out_word_o,
  input logic                           cfg_we_i,
  input logic [dtw_pkg::CLOCK_BITS-1:0] cfg_wdata_i
);
  import dtw_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // no new request while an update is only partly delivered
  a_busy_mid_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> in_stall_o)
    else $error("request taken in the middle of an update");

  // bank pins only on the last word, and both agree
  a_bank_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.freq_bank_sel == out_word_o.phase_bank_sel)
                 && (out_word_o.last || !out_word_o.freq_bank_sel))
    else $error("bank select pins wrong");

  // last word carries a phase address prefix
  a_phase_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last |->
      (out_word_o.spi_word[15:13] == 3'b111) || (out_word_o.spi_word[15:13] == 3'b110))
    else $error("last word without phase prefix");

endmodule

bind dds_tuning_word_writer_unit dtw_checker u_dtw_checker (.*);
